@@ rtl/b2da_pkg.sv @@
package b2da_pkg;

   // Values above this limit, and all negative values, print as stars.
   localparam logic [63:0] LIMIT_VALUE = 64'd99999999;
   localparam logic [63:0] STARS_WORD  = 64'h2A2A_2A2A_2A2A_2A2A;
   localparam logic [7:0]  CHAR_BLANK  = 8'h20;
   localparam logic [7:0]  CHAR_ZERO   = 8'h30;
   localparam logic [7:0]  CHAR_NUL    = 8'h00;

   localparam int unsigned DIGITS      = 8;
   localparam int unsigned DABBLE_BITS = 7;
   localparam int unsigned DABBLE_STAGES = 4;
   // Binary width carried through the shift-add-3 pipeline; 99999999 fits in 27 bits.
   localparam int unsigned VAL_W = DABBLE_BITS * DABBLE_STAGES;
   localparam int unsigned BCD_W = 4 * DIGITS;
   localparam int unsigned CNT_W = 4;

   typedef enum logic [1:0] {
      FUNC_BLANK_RIGHT = 2'd0,
      FUNC_NUL_LEFT    = 2'd1,
      FUNC_NUL_RIGHT   = 2'd2,
      FUNC_RESERVED    = 2'd3
   } func_type;

   typedef struct packed {
      logic             oor;
      logic [1:0]       func;
      logic [VAL_W-1:0] bin;
      logic [BCD_W-1:0] bcd;
   } stage_type;

   // One shift-add-3 step: correct every digit of 5 or more, then shift in one bit.
   function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                    input logic bit_in);
      logic [BCD_W-1:0] adj;
      adj = bcd;
      for (int d = 0; d < DIGITS; d++) begin
         if (adj[4*d +: 4] >= 4'd5) begin
            adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
         end
      end
      return {adj[BCD_W-2:0], bit_in};
   endfunction

endpackage

@@ rtl/b2da_dabble_stage.sv @@
module b2da_dabble_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  b2da_pkg::stage_type  in_data,
   output logic                 out_valid,
   output b2da_pkg::stage_type  out_data
);

   logic                valid_ff;
   b2da_pkg::stage_type data_ff;
   b2da_pkg::stage_type data_in;

   // Consume the top DABBLE_BITS bits of the binary value.
   always_comb begin
      data_in = in_data;
      for (int i = 0; i < b2da_pkg::DABBLE_BITS; i++) begin
         data_in.bcd = b2da_pkg::dabble_step(data_in.bcd, data_in.bin[b2da_pkg::VAL_W-1]);
         data_in.bin = {data_in.bin[b2da_pkg::VAL_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ rtl/binary_to_decimal_ascii_word_top.sv @@
// Converts a signed 64-bit number into eight packed ASCII characters, first character in
// bits 63..56. Values below zero or above 99999999 give eight '*'. req_func selects the
// layout: 0 (and 3) right-justified with blank fill, 1 left-justified with NUL fill,
// 2 right-justified with NUL fill. busy is always low: a new transaction is taken every
// cycle, and each result appears on rsp_text_word with rsp_strobe high for one cycle.
// The pipeline has one range-check stage, four shift-add-3 stages of seven bits
// each, and one formatting stage. The receiver cannot stall the block, so results
// must be captured when rsp_strobe is high.
module binary_to_decimal_ascii_word_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic signed [63:0] req_number,
   output logic        rsp_strobe,
   output logic [63:0] rsp_text_word
);

   logic                valid_ff [b2da_pkg::DABBLE_STAGES+1];
   b2da_pkg::stage_type data_ff  [b2da_pkg::DABBLE_STAGES+1];
   b2da_pkg::stage_type entry_in;

   logic        rsp_strobe_ff;
   logic [63:0] rsp_text_word_ff;
   logic [63:0] text_in;

   assign busy = 1'b0;

   // Range check and entry register.
   always_comb begin
      entry_in      = '0;
      entry_in.oor  = req_number[63] || (req_number > b2da_pkg::LIMIT_VALUE);
      entry_in.func = req_func;
      entry_in.bin  = req_number[b2da_pkg::VAL_W-1:0];
      entry_in.bcd  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= start;
      end
   end

   always_ff @(posedge clock) begin
      data_ff[0] <= entry_in;
   end

   for (genvar s = 0; s < b2da_pkg::DABBLE_STAGES; s++) begin : g_dabble
      b2da_dabble_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_ff[s]),
         .in_data   (data_ff[s]),
         .out_valid (valid_ff[s+1]),
         .out_data  (data_ff[s+1])
      );
   end

   // Formatting: count digits, then justify and fill, or give stars when out of range.
   always_comb begin
      b2da_pkg::stage_type      last;
      logic [b2da_pkg::CNT_W-1:0] count;
      logic [63:0]              digits;
      logic [63:0]              blanks;
      last   = data_ff[b2da_pkg::DABBLE_STAGES];
      count  = 4'd1;
      digits = '0;
      blanks = '0;
      for (int d = 1; d < b2da_pkg::DIGITS; d++) begin
         if (last.bcd[4*d +: 4] != 4'd0) begin
            count = 4'(d + 1);
         end
      end
      for (int d = 0; d < b2da_pkg::DIGITS; d++) begin
         if (d < int'(count)) begin
            digits[8*d +: 8] = b2da_pkg::CHAR_ZERO | {4'd0, last.bcd[4*d +: 4]};
         end else begin
            digits[8*d +: 8] = b2da_pkg::CHAR_NUL;
            blanks[8*d +: 8] = b2da_pkg::CHAR_BLANK;
         end
      end
      if (last.oor) begin
         text_in = b2da_pkg::STARS_WORD;
      end else begin
         unique case (b2da_pkg::func_type'(last.func))
            b2da_pkg::FUNC_NUL_LEFT:  text_in = digits << {3'(b2da_pkg::DIGITS - count), 3'b000};
            b2da_pkg::FUNC_NUL_RIGHT: text_in = digits;
            b2da_pkg::FUNC_BLANK_RIGHT,
            b2da_pkg::FUNC_RESERVED:  text_in = digits | blanks;
            default:                  text_in = digits | blanks;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= valid_ff[b2da_pkg::DABBLE_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      rsp_text_word_ff <= text_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_text_word = rsp_text_word_ff;

endmodule

@@ rtl/b2da_checker.sv @@
module b2da_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_func,
   input logic [63:0] req_number,
   input logic        rsp_strobe,
   input logic [63:0] rsp_text_word
);

   localparam int LATENCY = 6;

   a_never_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_strobe_follows_start : assert property (@(posedge clock) disable iff (reset)
      start |-> ##6 rsp_strobe)
      else $error("transaction lost");

   a_no_spurious_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LATENCY))
      else $error("result without transaction");

   a_negative_stars : assert property (@(posedge clock) disable iff (reset)
      (start && req_number[63]) |-> ##6 (rsp_text_word == b2da_pkg::STARS_WORD))
      else $error("negative number not starred");

   a_left_digit_first : assert property (@(posedge clock) disable iff (reset)
      (start && req_func == b2da_pkg::FUNC_NUL_LEFT && !req_number[63]
       && req_number <= b2da_pkg::LIMIT_VALUE)
      |-> ##6 (rsp_text_word[63:56] >= b2da_pkg::CHAR_ZERO
               && rsp_text_word[63:56] <= 8'h39))
      else $error("left-justified result does not open with a digit");

endmodule

bind binary_to_decimal_ascii_word_top b2da_checker u_b2da_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_func      (req_func),
   .req_number    (req_number),
   .rsp_strobe    (rsp_strobe),
   .rsp_text_word (rsp_text_word)
);

@@ bench/binary_to_decimal_ascii_word_top_tb.sv @@
`timescale 1ns / 100ps

module binary_to_decimal_ascii_word_top_tb;

   localparam int CYCLE_LIMIT = 60000;
   localparam int DRAIN_CYCLES = 12;

   typedef struct {
      b2da_pkg::func_type mode;
      logic signed [63:0] value;
      logic [63:0]        text;
   } conversion_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_func;
   logic signed [63:0] req_number;
   logic               rsp_strobe;
   logic [63:0]        rsp_text_word;

   conversion_type awaiting_text[$];
   int             items_sent;
   int             results_checked;
   int             error_count;
   int             cycle_count;
   int             stars_sent;
   logic           idling_enabled;

   binary_to_decimal_ascii_word_top uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_number    (req_number),
      .rsp_strobe    (rsp_strobe),
      .rsp_text_word (rsp_text_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Expected ASCII word for one conversion.
   function automatic logic [63:0] predict_text_word(input b2da_pkg::func_type mode,
                                                     input logic signed [63:0] value);
      logic [63:0] word;
      logic [63:0] rest;
      logic [7:0]  digit_chars[8];
      logic [7:0]  fill;
      int          ndigits;
      if (value[63] || value > b2da_pkg::LIMIT_VALUE) begin
         return b2da_pkg::STARS_WORD;
      end
      rest = value;
      ndigits = 0;
      do begin
         digit_chars[ndigits] = b2da_pkg::CHAR_ZERO + 8'(rest % 64'd10);
         rest = rest / 64'd10;
         ndigits++;
      end while (rest != 0);
      word = '0;
      if (mode == b2da_pkg::FUNC_NUL_LEFT) begin
         for (int i = 0; i < 8; i++) begin
            word[8*(7-i) +: 8] = (i < ndigits) ? digit_chars[ndigits-1-i]
                                               : b2da_pkg::CHAR_NUL;
         end
      end else begin
         fill = (mode == b2da_pkg::FUNC_NUL_RIGHT) ? b2da_pkg::CHAR_NUL
                                                   : b2da_pkg::CHAR_BLANK;
         for (int i = 0; i < 8; i++) begin
            word[8*i +: 8] = (i < ndigits) ? digit_chars[i] : fill;
         end
      end
      return word;
   endfunction

   // Drive one transaction and hold it until the block takes it.
   task automatic send_item(input b2da_pkg::func_type mode, input logic signed [63:0] value);
      conversion_type entry;
      @(negedge clock);
      start = 1'b1;
      req_func = mode;
      req_number = value;
      do @(posedge clock); while (busy);
      entry.mode = mode;
      entry.value = value;
      entry.text = predict_text_word(mode, value);
      awaiting_text.push_back(entry);
      items_sent++;
      if (entry.text == b2da_pkg::STARS_WORD) stars_sent++;
   endtask

   // Drop start for an idle stretch of length n, with junk on the fields.
   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start = 1'b0;
         req_func = 2'($urandom);
         req_number = {$urandom, $urandom};
      end
   endtask

   task automatic maybe_idle();
      if (idling_enabled && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 6));
   endtask

   function automatic logic signed [63:0] random_number();
      logic [63:0] low_bound;
      logic [63:0] high_bound;
      int          ndigits;
      case ($urandom_range(0, 9))
         7: return {$urandom, $urandom};
         8: return -64'sd1 * $signed(64'($urandom_range(1, 100000)));
         9: return b2da_pkg::LIMIT_VALUE + 64'($urandom_range(1, 1000));
         default: begin
            ndigits = $urandom_range(1, 8);
            low_bound = 1;
            repeat (ndigits - 1) low_bound = low_bound * 10;
            high_bound = low_bound * 10 - 1;
            if (ndigits == 1) low_bound = 0;
            return 64'($urandom_range(32'(low_bound), 32'(high_bound)));
         end
      endcase
   endfunction

   task automatic wait_until_drained();
      while (awaiting_text.size() != 0) @(posedge clock);
   endtask

   // Field extremes, every mode including the reserved one, and the range edges.
   task automatic test_directed();
      for (int m = 0; m < 4; m++) begin
         send_item(b2da_pkg::func_type'(m), 64'sd0);
         send_item(b2da_pkg::func_type'(m), 64'sd7);
         send_item(b2da_pkg::func_type'(m), 64'sd99999999);
      end
      send_item(b2da_pkg::FUNC_NUL_LEFT, -64'sd1);
      send_item(b2da_pkg::FUNC_NUL_RIGHT, 64'sh8000_0000_0000_0000);
      send_item(b2da_pkg::FUNC_BLANK_RIGHT, 64'sh7FFF_FFFF_FFFF_FFFF);
      send_item(b2da_pkg::FUNC_NUL_LEFT, 64'sd100000000);
      send_item(b2da_pkg::FUNC_RESERVED, 64'sd12345);
      send_item(b2da_pkg::FUNC_NUL_RIGHT, 64'sd10000000);
      send_item(b2da_pkg::FUNC_NUL_LEFT, 64'sd1000);
      send_item(b2da_pkg::FUNC_BLANK_RIGHT, 64'sd4560);
   endtask

   // Hold the sender until every outstanding result has come back.
   task automatic test_pause_until_empty();
      idle_cycles(1);
      wait_until_drained();
      send_item(b2da_pkg::FUNC_NUL_LEFT, 64'sd12345678);
      send_item(b2da_pkg::FUNC_BLANK_RIGHT, 64'sd9);
   endtask

   task automatic test_random_values();
      for (int i = 0; i < 480; i++) begin
         // alternate stretches with and without gaps
         idling_enabled = ((i / 40) % 2) == 0;
         send_item(b2da_pkg::func_type'($urandom_range(0, 3)), random_number());
         maybe_idle();
      end
   endtask

   task automatic test_back_to_back();
      idling_enabled = 1'b0;
      for (int i = 0; i < 50; i++) begin
         send_item(b2da_pkg::func_type'($urandom_range(0, 3)), random_number());
      end
      idle_cycles(1);
   endtask

   always @(posedge clock) begin
      conversion_type entry;
      if (!reset && rsp_strobe) begin
         if (awaiting_text.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $time, rsp_text_word);
            error_count++;
         end else begin
            entry = awaiting_text.pop_front();
            results_checked++;
            if (rsp_text_word !== entry.text) begin
               $display("%0t: text_word mismatch (func %0d number %0d) expected %h actual %h",
                        $time, entry.mode, entry.value, entry.text, rsp_text_word);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, awaiting_text.size());
         $display("binary_to_decimal_ascii_word_top regression: fail");
         $finish;
      end
   end

   initial begin
      items_sent = 0;
      results_checked = 0;
      error_count = 0;
      cycle_count = 0;
      stars_sent = 0;
      idling_enabled = 1'b1;
      reset = 1'b1;
      start = 1'b0;
      req_func = '0;
      req_number = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_pause_until_empty();
      test_random_values();
      test_back_to_back();

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaiting_text.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, awaiting_text.size());
         error_count++;
      end

      $display("Converted %0d numbers in all four modes, %0d of them out of range;",
               items_sent, stars_sent);
      $display("%0d results checked, %0d errors.", results_checked, error_count);
      if (error_count == 0) begin
         $display("binary_to_decimal_ascii_word_top regression: pass");
      end else begin
         $display("binary_to_decimal_ascii_word_top regression: fail");
      end
      $finish;
   end

endmodule
